[rtl/fccw_pkg.sv]
// Package for the FAT12 cluster chain walker: field widths, codes, reset values
// and the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package fccw_pkg;

    // Field widths.
    localparam int ENTRY_W  = 12;
    localparam int SECTOR_W = 16;
    localparam int COUNT_W  = 8;
    localparam int SBYTES_W = 13;
    localparam int OFFSET_W = 32;
    localparam int GROW_W   = SBYTES_W + COUNT_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Stream packing.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 88;

    // Restoring divider: one quotient bit per step.
    localparam int DIV_STEPS = SBYTES_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Table entry markers.
    localparam logic [ENTRY_W-1:0] END_MARK = 12'hFF8;
    localparam logic [ENTRY_W-1:0] BAD_MARK = 12'hFF7;
    localparam logic [ENTRY_W-1:0] MIN_CLUSTER = 12'd2;

    // Configuration reset values.
    localparam logic [COUNT_W-1:0]  RST_SPC = 8'd1;
    localparam logic [SBYTES_W-1:0] RST_SB  = 13'd512;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPC = 2'd0,
        CFG_SB  = 2'd1,
        CFG_DSS = 2'd2,
        CFG_TSS = 2'd3
    } t_cfg_reg;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_TABLE = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    // End status codes.
    typedef enum logic [1:0] {
        END_CONT  = 2'd0,
        END_CHAIN = 2'd1,
        END_BAD   = 2'd2
    } t_end;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load_in;
        logic  eval;
        logic  prep;
        logic  div_step;
        logic  load_out;
        t_kind out_kind;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ignore;
        logic finish;
        logic div_done;
    } t_stat;

endpackage

[rtl/fccw_ctrl.sv]
// Controller state machine of the FAT12 cluster chain walker.
// Sequences evaluation, division and result output; uses fccw_pkg.
`timescale 1ns / 1ps

module fccw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    input  fccw_pkg::t_stat i_stat,
    output fccw_pkg::t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_EVAL  = 7'b0000010,
        ST_PREP  = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_DATA  = 7'b0010000,
        ST_TABLE = 7'b0100000,
        ST_FIN   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.out_kind = fccw_pkg::KIND_DATA;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_stat.ignore) begin
                    n_state = ST_IDLE;
                end else if (i_stat.finish) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = ST_DATA;
                end
            end
            ST_DATA: begin
                o_cmd.out_kind = fccw_pkg::KIND_DATA;
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_TABLE;
                end
            end
            ST_TABLE: begin
                o_cmd.out_kind = fccw_pkg::KIND_TABLE;
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_FIN: begin
                o_cmd.out_kind = fccw_pkg::KIND_DONE;
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // The output slot is full from a load until the downstream transaction.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/fccw_dpath.sv]
// Datapath of the FAT12 cluster chain walker: configuration registers, chain
// state, entry decode, sector arithmetic, divider and output registers.
// Uses fccw_pkg; driven by fccw_ctrl.
`timescale 1ns / 1ps

module fccw_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [fccw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fccw_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    input  logic                                i_op,
    input  logic [fccw_pkg::ENTRY_W-1:0]        i_start,
    input  logic [fccw_pkg::SECTOR_W-1:0]       i_word,
    input  fccw_pkg::t_cmd                      i_cmd,
    output fccw_pkg::t_stat                     o_stat,
    output logic [1:0]                          o_kind,
    output logic [fccw_pkg::SECTOR_W-1:0]       o_sector,
    output logic [fccw_pkg::COUNT_W-1:0]        o_count,
    output logic [fccw_pkg::ENTRY_W-1:0]        o_index,
    output logic [fccw_pkg::OFFSET_W-1:0]       o_dest,
    output logic [fccw_pkg::ENTRY_W-1:0]        o_cluster,
    output logic [1:0]                          o_status,
    output logic                                o_last
);

    // Configuration.
    logic [fccw_pkg::COUNT_W-1:0]  r_spc;
    logic [fccw_pkg::SBYTES_W-1:0] r_sb;
    logic [fccw_pkg::SECTOR_W-1:0] r_dss;
    logic [fccw_pkg::SECTOR_W-1:0] r_tss;

    // Latched input item.
    logic                          r_op;
    logic [fccw_pkg::ENTRY_W-1:0]  r_start;
    logic [fccw_pkg::SECTOR_W-1:0] r_word;

    // Chain state.
    logic [fccw_pkg::ENTRY_W-1:0]  r_cluster;
    logic [fccw_pkg::OFFSET_W-1:0] r_offset;
    logic                          r_active;
    fccw_pkg::t_end                r_end_code;

    // Link arithmetic.
    logic [fccw_pkg::SECTOR_W-1:0] r_dprod;
    logic [fccw_pkg::GROW_W-1:0]   r_grow;
    logic [fccw_pkg::SBYTES_W-1:0] r_toff;
    logic [fccw_pkg::SBYTES_W-1:0] r_rem;
    logic [fccw_pkg::SBYTES_W-1:0] r_quo;
    logic [fccw_pkg::DIV_CNT_W-1:0] r_div_cnt;

    // Output registers.
    logic [1:0]                    r_kind;
    logic [fccw_pkg::SECTOR_W-1:0] r_sector;
    logic [fccw_pkg::COUNT_W-1:0]  r_count;
    logic [fccw_pkg::ENTRY_W-1:0]  r_index;
    logic [fccw_pkg::OFFSET_W-1:0] r_dest;
    logic [fccw_pkg::ENTRY_W-1:0]  r_cnow;
    logic [1:0]                    r_status;
    logic                          r_last;

    logic [fccw_pkg::ENTRY_W-1:0]  w_entry;
    logic                          w_end;
    logic                          w_bad;
    logic                          w_start_bad;
    logic                          w_finish;
    fccw_pkg::t_end                w_code;
    logic [fccw_pkg::SBYTES_W:0]   w_trial;
    logic                          w_fits;
    logic [fccw_pkg::SECTOR_W-1:0] w_cminus2;

    // Entry decode by the parity of the current cluster.
    assign w_entry = r_cluster[0] ? r_word[15:4] : r_word[11:0];
    assign w_end   = (w_entry >= fccw_pkg::END_MARK);
    assign w_bad   = (w_entry == fccw_pkg::BAD_MARK) || (w_entry < fccw_pkg::MIN_CLUSTER);
    assign w_start_bad = (r_start < fccw_pkg::MIN_CLUSTER);

    always_comb begin
        if (r_op) begin
            w_finish = w_end || w_bad;
            w_code   = w_end ? fccw_pkg::END_CHAIN : fccw_pkg::END_BAD;
        end else begin
            w_finish = w_start_bad;
            w_code   = fccw_pkg::END_BAD;
        end
    end

    assign o_stat.ignore   = r_op && !r_active;
    assign o_stat.finish   = w_finish;
    assign o_stat.div_done = (r_div_cnt == fccw_pkg::DIV_CNT_W'(fccw_pkg::DIV_STEPS - 1));

    // One restoring division step.
    assign w_trial = {r_rem, r_quo[fccw_pkg::SBYTES_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_sb});

    // Cluster minus two, wrapping at the sector width.
    assign w_cminus2 = fccw_pkg::SECTOR_W'(r_cluster) - fccw_pkg::SECTOR_W'(2);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spc <= fccw_pkg::RST_SPC;
            r_sb  <= fccw_pkg::RST_SB;
            r_dss <= '0;
            r_tss <= '0;
        end else if (i_cfg_valid) begin
            case (fccw_pkg::t_cfg_reg'(i_cfg_index))
                fccw_pkg::CFG_SPC: r_spc <= i_cfg_data[fccw_pkg::COUNT_W-1:0];
                fccw_pkg::CFG_SB:  r_sb  <= i_cfg_data[fccw_pkg::SBYTES_W-1:0];
                fccw_pkg::CFG_DSS: r_dss <= i_cfg_data;
                fccw_pkg::CFG_TSS: r_tss <= i_cfg_data;
                default: r_dss <= r_dss;
            endcase
        end
    end

    // Chain state updates at evaluation and at the data request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster  <= '0;
            r_offset   <= '0;
            r_active   <= 1'b0;
            r_end_code <= fccw_pkg::END_CONT;
        end else begin
            if (i_cmd.eval) begin
                r_end_code <= w_code;
                if (!r_op) begin
                    r_cluster <= r_start;
                    r_offset  <= '0;
                    r_active  <= !w_finish;
                end else if (r_active) begin
                    if (w_finish) begin
                        r_active <= 1'b0;
                    end else begin
                        r_cluster <= w_entry;
                    end
                end
            end
            if (i_cmd.load_out && (i_cmd.out_kind == fccw_pkg::KIND_DATA)) begin
                r_offset <= r_offset + fccw_pkg::OFFSET_W'(r_grow);
            end
        end
    end

    // Input latch, products and divider.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op    <= i_op;
            r_start <= i_start;
            r_word  <= i_word;
        end
        if (i_cmd.prep) begin
            r_dprod   <= fccw_pkg::SECTOR_W'(w_cminus2 * r_spc);
            r_grow    <= r_sb * r_spc;
            r_toff    <= fccw_pkg::SBYTES_W'(r_cluster) +
                         fccw_pkg::SBYTES_W'(r_cluster[fccw_pkg::ENTRY_W-1:1]);
            r_quo     <= fccw_pkg::SBYTES_W'(r_cluster) +
                         fccw_pkg::SBYTES_W'(r_cluster[fccw_pkg::ENTRY_W-1:1]);
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= w_fits ? fccw_pkg::SBYTES_W'(w_trial - {1'b0, r_sb})
                                : w_trial[fccw_pkg::SBYTES_W-1:0];
            r_quo     <= {r_quo[fccw_pkg::SBYTES_W-2:0], w_fits};
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_kind <= i_cmd.out_kind;
            r_cnow <= r_cluster;
            case (i_cmd.out_kind)
                fccw_pkg::KIND_DATA: begin
                    r_sector <= r_dprod + r_dss;
                    r_count  <= r_spc;
                    r_index  <= '0;
                    r_dest   <= r_offset;
                    r_status <= fccw_pkg::END_CONT;
                    r_last   <= 1'b0;
                end
                fccw_pkg::KIND_TABLE: begin
                    // A zero sector size keeps the table start sector and leaves the
                    // low 12 bits of the table offset as the index.
                    r_sector <= (r_sb == '0) ? r_tss
                                             : r_tss + fccw_pkg::SECTOR_W'(r_quo);
                    r_count  <= fccw_pkg::COUNT_W'(1);
                    r_index  <= (r_sb == '0) ? r_toff[fccw_pkg::ENTRY_W-1:0]
                                             : r_rem[fccw_pkg::ENTRY_W-1:0];
                    r_dest   <= '0;
                    r_status <= fccw_pkg::END_CONT;
                    r_last   <= 1'b1;
                end
                default: begin
                    r_sector <= '0;
                    r_count  <= '0;
                    r_index  <= '0;
                    r_dest   <= r_offset;
                    r_status <= r_end_code;
                    r_last   <= 1'b1;
                end
            endcase
        end
    end

    assign o_kind    = r_kind;
    assign o_sector  = r_sector;
    assign o_count   = r_count;
    assign o_index   = r_index;
    assign o_dest    = r_dest;
    assign o_cluster = r_cnow;
    assign o_status  = r_status;
    assign o_last    = r_last;

endmodule

[rtl/fat12_cluster_chain_walker_unit.sv]
// Top level of the FAT12 cluster chain walker; uses fccw_pkg, fccw_ctrl, fccw_dpath.
// One item at a time. A start or link item is evaluated, its sector products are
// prepared and the 13-step table-offset divider runs; then its data request and its
// table request are shown in turn, and the next item is taken once the table request
// is loaded. An ending item shows its finished result before the next is taken; a
// table word while no chain is active gives nothing.
// Reset (synchronous, active low) ends the chain, restores the configuration defaults
// and empties the output register.
`timescale 1ns / 1ps

module fat12_cluster_chain_walker_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fccw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fccw_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    // Input stream.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [fccw_pkg::S_TDATA_W-1:0]      i_s_tdata,  // start_cluster, table_word
    input  logic [0:0]                          i_s_tuser,  // operation
    // Output stream.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // sector_number, sector_count, byte_index, dest_offset, cluster_now, end_status
    output logic [fccw_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic [1:0]                          o_m_tuser,  // request_kind
    output logic                                o_m_tlast
);

    fccw_pkg::t_cmd  w_cmd;
    fccw_pkg::t_stat w_stat;

    logic [fccw_pkg::SECTOR_W-1:0] w_sector;
    logic [fccw_pkg::COUNT_W-1:0]  w_count;
    logic [fccw_pkg::ENTRY_W-1:0]  w_index;
    logic [fccw_pkg::OFFSET_W-1:0] w_dest;
    logic [fccw_pkg::ENTRY_W-1:0]  w_cluster;
    logic [1:0]                    w_status;

    // Registers are always writable.
    assign o_cfg_ready = 1'b1;

    fccw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    fccw_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (i_s_tuser[0]),
        .i_start     (i_s_tdata[11:0]),
        .i_word      (i_s_tdata[27:12]),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_kind      (o_m_tuser),
        .o_sector    (w_sector),
        .o_count     (w_count),
        .o_index     (w_index),
        .o_dest      (w_dest),
        .o_cluster   (w_cluster),
        .o_status    (w_status),
        .o_last      (o_m_tlast)
    );

    // Pack the result fields, lowest first, padded to whole bytes.
    assign o_m_tdata = {6'b0, w_status, w_cluster, w_dest, w_index, w_count, w_sector};

endmodule

[rtl/fccw_checker.sv]
// Port-level checks for the FAT12 cluster chain walker, bound to its top level.
// Uses fccw_pkg.
`timescale 1ns / 1ps

module fccw_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic                                o_cfg_ready,
    input  logic [fccw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fccw_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    input  logic                                i_s_tvalid,
    input  logic                                o_s_tready,
    input  logic [fccw_pkg::S_TDATA_W-1:0]      i_s_tdata,
    input  logic [0:0]                          i_s_tuser,
    input  logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [fccw_pkg::M_TDATA_W-1:0]      o_m_tdata,
    input  logic [1:0]                          o_m_tuser,
    input  logic                                o_m_tlast
);

    // A stalled result stays put until the transaction completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // A data request is always followed by its table request, so it is never last.
    a_data_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == fccw_pkg::KIND_DATA) |->
            !o_m_tlast && (o_m_tdata[81:80] == fccw_pkg::END_CONT))
        else $error("data request marked last or ending");

    // A table request reads one sector and closes the link.
    a_table_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == fccw_pkg::KIND_TABLE) |->
            o_m_tlast && (o_m_tdata[23:16] == 8'd1) && (o_m_tdata[67:36] == 32'd0))
        else $error("malformed table request");

    // A finished result carries an ending status and no sector request.
    a_done_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == fccw_pkg::KIND_DONE) |->
            o_m_tlast && (o_m_tdata[81:80] != fccw_pkg::END_CONT) &&
            (o_m_tdata[23:0] == 24'd0))
        else $error("malformed finished result");

endmodule

bind fat12_cluster_chain_walker_unit fccw_checker u_fccw_checker (.*);

[sim/tb_fat12_cluster_chain_walker_unit.sv]
// Self-checking testbench for the FAT12 cluster chain walker: a scoreboard class
// predicts every request and ending from the accepted items and checks the output stream.
// Depends on fccw_pkg and fat12_cluster_chain_walker_unit.
`timescale 1ns / 1ps

module tb_fat12_cluster_chain_walker_unit;
    import fccw_pkg::*;

    // Operation codes carried in the input tuser.
    localparam logic OP_START = 1'b0;
    localparam logic OP_WORD  = 1'b1;

    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 132;

    // One expected request or ending, field by field.
    typedef struct {
        t_kind                kind;
        logic [SECTOR_W-1:0]  sector;
        logic [COUNT_W-1:0]   count;
        logic [ENTRY_W-1:0]   index;
        logic [OFFSET_W-1:0]  dest;
        logic [ENTRY_W-1:0]   cluster;
        t_end                 status;
        logic                 last;
    } chain_req_t;

    // Tracks the chain and the volume geometry, and holds the requests still owed.
    class chain_walk_board;
        logic [COUNT_W-1:0]  spc = RST_SPC;
        logic [SBYTES_W-1:0] sbytes = RST_SB;
        logic [SECTOR_W-1:0] data_base = '0;
        logic [SECTOR_W-1:0] table_base = '0;
        logic [ENTRY_W-1:0]  cluster = '0;
        logic [OFFSET_W-1:0] offset = '0;
        bit                  active = 1'b0;
        int                  errors = 0;
        chain_req_t          expected_reqs[$];

        function void write_reg(t_cfg_reg idx, logic [CFG_DAT_W-1:0] value);
            case (idx)
                CFG_SPC: spc = value[COUNT_W-1:0];
                CFG_SB:  sbytes = value[SBYTES_W-1:0];
                CFG_DSS: data_base = value;
                CFG_TSS: table_base = value;
                default: ;
            endcase
        endfunction

        function void push_req(t_kind kind, int unsigned sector, int unsigned count,
                               int unsigned index, logic [OFFSET_W-1:0] dest,
                               t_end status, logic last);
            chain_req_t r;
            r.kind    = kind;
            r.sector  = sector[SECTOR_W-1:0];
            r.count   = count[COUNT_W-1:0];
            r.index   = index[ENTRY_W-1:0];
            r.dest    = dest;
            r.cluster = cluster;
            r.status  = status;
            r.last    = last;
            expected_reqs.push_back(r);
        endfunction

        function void end_chain(t_end status);
            active = 1'b0;
            push_req(KIND_DONE, 0, 0, 0, offset, status, 1'b1);
        endfunction

        // Data read of the current cluster, then the read of its table word.
        function void queue_link();
            int unsigned c;
            int unsigned toff;
            int unsigned tsec;
            int unsigned idx;
            c    = cluster;
            toff = c + (c >> 1);
            if (sbytes != 0) begin
                tsec = table_base + toff / sbytes;
                idx  = toff % sbytes;
            end else begin
                tsec = table_base;
                idx  = toff;
            end
            push_req(KIND_DATA, (c - 2) * spc + data_base, spc, 0, offset, END_CONT, 1'b0);
            offset = offset + sbytes * spc;
            push_req(KIND_TABLE, tsec, 1, idx, '0, END_CONT, 1'b1);
        endfunction

        // Called once per accepted input transaction.
        function void note_input(logic op, logic [ENTRY_W-1:0] start, logic [15:0] word);
            logic [ENTRY_W-1:0] entry;
            if (op == OP_START) begin
                cluster = start;
                offset  = '0;
                active  = 1'b1;
                if (cluster < MIN_CLUSTER) end_chain(END_BAD);
                else queue_link();
            end else if (active) begin
                // Odd clusters keep the upper 12 bits, even ones the lower.
                entry = cluster[0] ? word[15:4] : word[11:0];
                if (entry >= END_MARK) begin
                    end_chain(END_CHAIN);
                end else if (entry == BAD_MARK || entry < MIN_CLUSTER) begin
                    end_chain(END_BAD);
                end else begin
                    cluster = entry;
                    queue_link();
                end
            end
        endfunction

        function void compare_field(string field, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        // Called once per accepted output transaction.
        function void check_result(logic [M_TDATA_W-1:0] tdata, logic [1:0] tuser, logic tlast);
            chain_req_t e;
            if (expected_reqs.size() == 0) begin
                $error("result with nothing pending: tuser %0d tdata 0x%0h", tuser, tdata);
                errors++;
                return;
            end
            e = expected_reqs.pop_front();
            compare_field("request_kind", e.kind, tuser);
            compare_field("sector_number", e.sector, tdata[15:0]);
            compare_field("sector_count", e.count, tdata[23:16]);
            compare_field("byte_index", e.index, tdata[35:24]);
            compare_field("dest_offset", e.dest, tdata[67:36]);
            compare_field("cluster_now", e.cluster, tdata[79:68]);
            compare_field("end_status", e.status, tdata[81:80]);
            compare_field("last", e.last, tlast);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]   i_cfg_data = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata = '0;   // start_cluster, table_word
    logic [0:0]             i_s_tuser = '0;   // operation
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // sector_number, sector_count, byte_index, dest_offset, cluster_now, end_status
    logic [M_TDATA_W-1:0]   o_m_tdata;
    logic [1:0]             o_m_tuser;        // request_kind
    logic                   o_m_tlast;

    chain_walk_board walk_board;
    bit  sender_gaps = 1'b0;
    bit  quiet_tail = 1'b0;
    int  phase_count = 0;
    int  cycle_count = 0;

    fat12_cluster_chain_walker_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Output monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            walk_board.check_result(o_m_tdata, o_m_tuser, o_m_tlast);
    end

    // Receiver: bursts of stall between stretches of ready, none in the tail.
    initial begin
        wait (i_rst_n);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Presents one item and holds it until the transaction completes.
    task automatic send_item(logic op, logic [ENTRY_W-1:0] start, logic [15:0] word);
        if (sender_gaps && !quiet_tail && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {4'd0, word, start};
        do @(posedge i_clk); while (!o_s_tready);
        walk_board.note_input(op, start, word);
        phase_count++;
    endtask

    // Sends a table word that decodes to the given entry for the current cluster.
    task automatic send_entry(logic [ENTRY_W-1:0] entry);
        logic [3:0]  pad;
        logic [15:0] word;
        pad  = 4'($urandom);
        word = walk_board.cluster[0] ? {entry, pad} : {pad, entry};
        send_item(OP_WORD, 12'($urandom_range(0, 4095)), word);
    endtask

    // Stops the sender and waits until the block is idle.
    task automatic drain_outputs();
        i_s_tvalid <= 1'b0;
        while (walk_board.expected_reqs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_reg idx, logic [CFG_DAT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        walk_board.write_reg(idx, value);
    endtask

    task automatic configure(logic [15:0] spc, logic [15:0] sbytes,
                             logic [15:0] dbase, logic [15:0] tbase);
        drain_outputs();
        cfg_write(CFG_SPC, spc);
        cfg_write(CFG_SB, sbytes);
        cfg_write(CFG_DSS, dbase);
        cfg_write(CFG_TSS, tbase);
        i_cfg_valid <= 1'b0;
    endtask

    // A start, a few links with random content, then an ending, a random word or none.
    task automatic walk_chain();
        int links;
        logic [ENTRY_W-1:0] first;
        sender_gaps = ($urandom_range(0, 2) != 0);
        first = ($urandom_range(0, 19) == 0) ? 12'($urandom_range(0, 1))
                                             : 12'($urandom_range(2, 4095));
        send_item(OP_START, first, 16'($urandom));
        links = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
        for (int k = 0; k < links && walk_board.active; k++)
            send_entry(12'($urandom_range(2, 12'hFF6)));
        if (walk_board.active) begin
            case ($urandom_range(0, 5))
                0, 1: send_entry(12'($urandom_range(12'hFF8, 12'hFFF)));
                2:    send_entry(BAD_MARK);
                3:    send_entry(12'($urandom_range(0, 1)));
                4:    ;  // left open; the next start abandons it
                default: send_item(OP_WORD, 12'($urandom_range(0, 4095)), 16'($urandom));
            endcase
        end
    endtask

    initial begin
        bit paused;
        walk_board = new;
        paused = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset geometry.
        send_item(OP_WORD, 12'hFFF, 16'hFFFF);  // word with no chain: ignored
        send_item(OP_START, 12'd0, 16'h0000);   // invalid start clusters
        send_item(OP_START, 12'd1, 16'hFFFF);
        send_item(OP_WORD, 12'd0, 16'h0000);    // ignored after an ending
        send_item(OP_START, 12'd2, 16'h0000);   // lowest valid cluster, even
        send_item(OP_WORD, 12'd0, 16'h0003);    // link to 3
        send_item(OP_WORD, 12'd0, 16'hFF6F);    // odd cluster: link to 0xFF6
        send_item(OP_WORD, 12'd0, 16'hFFF7);    // bad marker
        send_item(OP_START, 12'hFFF, 16'h0000); // highest cluster
        send_item(OP_WORD, 12'd0, 16'hFF80);    // lowest end marker
        send_item(OP_START, 12'd5, 16'h0000);
        send_item(OP_WORD, 12'd0, 16'h0010);    // entry 1 is invalid
        send_item(OP_START, 12'd6, 16'h0000);
        send_item(OP_WORD, 12'd0, 16'hF000);    // entry 0 is invalid
        send_item(OP_START, 12'd7, 16'h0000);
        send_item(OP_START, 12'd8, 16'h0000);   // restart while a chain runs
        send_item(OP_WORD, 12'd0, 16'hFFFF);    // highest end marker
        send_item(OP_START, 12'd9, 16'h0000);
        send_item(OP_WORD, 12'd0, 16'h00A0);    // link to 0x00A
        send_item(OP_WORD, 12'd0, 16'h0FFF);    // end of chain

        // Random part, one geometry per phase.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: configure(16'd128, 16'd4096, 16'hFFFF, 16'hFFFF);
                1: configure(16'd0, 16'd0, 16'd0, 16'd0);
                2: configure(16'd255, 16'd8191, 16'($urandom), 16'($urandom));
                3: configure(16'd1, 16'd512, 16'd0, 16'd0);
                default: configure(16'($urandom_range(1, 128)), 16'($urandom_range(512, 4096)),
                                   16'($urandom), 16'($urandom));
            endcase
            if (p == PHASES - 1) quiet_tail = 1'b1;
            phase_count = 0;
            while (phase_count < PHASE_ITEMS) begin
                // Hold the sender once until every owed result has come back.
                if (p == 4 && !paused && phase_count >= PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    i_s_tvalid <= 1'b0;
                    while (walk_board.expected_reqs.size() != 0) @(posedge i_clk);
                end
                case ($urandom_range(0, 9))
                    8: send_item(OP_WORD, 12'($urandom_range(0, 4095)), 16'($urandom));
                    9: send_item(OP_START, 12'($urandom_range(0, 4095)), 16'($urandom));
                    default: walk_chain();
                endcase
            end
        end

        drain_outputs();
        if (walk_board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/fccw_pkg.sv
rtl/fccw_ctrl.sv
rtl/fccw_dpath.sv
rtl/fat12_cluster_chain_walker_unit.sv
rtl/fccw_checker.sv
sim/tb_fat12_cluster_chain_walker_unit.sv
